// ===== design/colour_to_label_indexer_core_macros.svh =====
// Assertion macros shared by the colour-to-label indexer RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef COLOUR_TO_LABEL_INDEXER_CORE_MACROS_SVH
`define COLOUR_TO_LABEL_INDEXER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk_i while rst_ni is high.
`define CTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define CTI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define CTI_ASSERT(name, prop, msg)
`define CTI_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== design/cti_pkg.sv =====
// Types and constants for the colour-to-label indexer.
// No dependencies; used by cti_cam and colour_to_label_indexer_core.
package cti_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned ColourW    = 3 * ChanW;
  localparam int unsigned LabelW     = 8;
  localparam int unsigned FirstLabel = 10;
  localparam int unsigned TableDepth = (1 << LabelW) - FirstLabel;
  localparam int unsigned SlotW      = $clog2(TableDepth);

  typedef logic [ChanW-1:0]   chan_t;
  typedef logic [ColourW-1:0] colour_t;
  typedef logic [LabelW-1:0]  label_t;
  typedef logic [SlotW-1:0]   slot_t;

  localparam label_t LabelBlack = label_t'(0);
  localparam label_t LabelWhite = label_t'(1);
  localparam label_t LabelFirst = label_t'(FirstLabel);
  localparam label_t LabelLast  = '1;

  localparam colour_t ColourBlack = '0;
  localparam colour_t ColourWhite = '1;

  typedef struct packed {
    logic    en;
    slot_t   slot;
    colour_t key;
  } cti_wr_t;

  typedef struct packed {
    logic   hit;
    label_t label;
  } cti_match_t;

endpackage

// ===== design/cti_cam.sv =====
// Colour table with one parallel compare per entry and one write port.
// Depends on cti_pkg.
module cti_cam import cti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  colour_t    key_i,
  input  cti_wr_t    wr_i,
  output cti_match_t match_o
);

  colour_t                stored_q [TableDepth];
  logic [TableDepth-1:0]  valid_q;
  logic [TableDepth-1:0]  hit_vec;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      stored_q[wr_i.slot] <= wr_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.slot] <= 1'b1;
    end
  end

  // Each colour is stored at most once, so at most one entry hits and the
  // label can be formed by a plain OR over the entries.
  always_comb begin
    match_o.label = '0;
    for (int i = 0; i < TableDepth; i++) begin
      hit_vec[i] = valid_q[i] && (stored_q[i] == key_i);
      if (hit_vec[i]) begin
        match_o.label = match_o.label | label_t'(FirstLabel + i);
      end
    end
    match_o.hit = |hit_vec;
  end

endmodule

// ===== design/colour_to_label_indexer_core.sv =====
// Each pixel beat is registered in stage 1, then its label beat in the output register.
// Throughput: one beat per cycle while the label side takes beats; the colour table is
// searched combinationally by a compare per entry, and a new colour is written on advance.
// Reset invalidates every table entry, sets the next label to 10 and clears the
// overflow flag; it takes effect at once, with no clearing pass.
// Depends on cti_pkg, cti_cam and colour_to_label_indexer_core_macros.svh.
`include "colour_to_label_indexer_core_macros.svh"

module colour_to_label_indexer_core import cti_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  chan_t  first_channel_i,
  input  chan_t  second_channel_i,
  input  chan_t  third_channel_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output label_t label_o,
  output logic   overflow_error_o
);

  logic       s1_valid_q;
  colour_t    s1_key_q;
  logic       advance;

  label_t     next_label_q, next_label_d;
  logic       error_q, error_d;

  logic       out_valid_q;
  label_t     out_label_q, res_label;
  logic       out_err_q, res_err;

  cti_wr_t    wr;
  cti_match_t match;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_key_q <= {first_channel_i, second_channel_i, third_channel_i};
    end
  end

  cti_cam u_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (s1_key_q),
    .wr_i   (wr),
    .match_o(match)
  );

  always_comb begin
    res_label    = LabelBlack;
    res_err      = 1'b0;
    next_label_d = next_label_q;
    error_d      = error_q;
    wr.en        = 1'b0;
    wr.slot      = slot_t'(next_label_q - LabelFirst);
    wr.key       = s1_key_q;
    if (error_q) begin
      res_err = 1'b1;
    end else if (s1_key_q == ColourBlack) begin
      res_label = LabelBlack;
    end else if (s1_key_q == ColourWhite) begin
      res_label = LabelWhite;
    end else if (match.hit) begin
      res_label = match.label;
    end else begin
      res_label = next_label_q;
      wr.en     = advance;
      if (next_label_q == LabelLast) begin
        res_err = 1'b1;
        error_d = 1'b1;
      end else begin
        next_label_d = next_label_q + label_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_label_q <= LabelFirst;
      error_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        next_label_q <= next_label_d;
        error_q      <= error_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_label_q <= res_label;
      out_err_q   <= res_err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign label_o          = out_label_q;
  assign overflow_error_o = out_err_q;

  `CTI_ASSERT(a_error_sticky, error_q |=> error_q, "overflow flag cleared without reset")
  `CTI_ASSERT(a_next_label_range, next_label_q >= LabelFirst, "next label below first label")
  `CTI_ASSERT(a_err_label,
    out_valid_o && overflow_error_o |-> label_o == LabelBlack || label_o == LabelLast,
    "overflow beat with unexpected label")
  `CTI_ASSERT(a_label_range,
    out_valid_o |-> label_o == LabelBlack || label_o == LabelWhite || label_o >= LabelFirst,
    "label outside the assigned ranges")

endmodule
